// ----- rtl/core/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier package
// Widths, register map, reset values and result codes shared by the block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int DURATION_BITS = 16;
	localparam int TICKS_BITS    = 16;
	localparam int CMP_BITS      = (DURATION_BITS > TICKS_BITS) ? DURATION_BITS : TICKS_BITS;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;
	localparam int REG_IDX_BITS = 3;

	typedef logic [DURATION_BITS-1:0] duration_t;
	typedef logic [1:0]               code_t;

	// Register indexes.
	localparam logic [REG_IDX_BITS-1:0] REG_INTEGRATOR_LIMIT   = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_HELD_THRESHOLD     = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_RELEASED_THRESHOLD = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_LONG_PRESS_TICKS   = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_SHORT_PRESS_TICKS  = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_LONG_PRESS_ENABLE  = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_SHORT_PRESS_ENABLE = 3'd6;

	// Reset values.
	localparam logic [7:0]            RST_INTEGRATOR_LIMIT   = 8'd110;
	localparam logic [7:0]            RST_HELD_THRESHOLD     = 8'd100;
	localparam logic [7:0]            RST_RELEASED_THRESHOLD = 8'd10;
	localparam logic [TICKS_BITS-1:0] RST_LONG_PRESS_TICKS   = 16'd1000;
	localparam logic [TICKS_BITS-1:0] RST_SHORT_PRESS_TICKS  = 16'd50;

	// Event codes.
	localparam code_t EVENT_NONE  = 2'd0;
	localparam code_t EVENT_PRESS = 2'd1;
	localparam code_t EVENT_LONG  = 2'd2;

	// Debounced level codes.
	localparam code_t LEVEL_RELEASED = 2'd0;
	localparam code_t LEVEL_BETWEEN  = 2'd1;
	localparam code_t LEVEL_HELD     = 2'd2;

endpackage

// ----- rtl/core/bpc_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one sampled button pin level per transaction.
// ----------------------------------------------------------------------------
interface bpc_sample_if;
	logic valid;
	logic ready;
	logic pin_high;

	modport source (output valid, output pin_high, input ready);
	modport sink (input valid, input pin_high, output ready);
endinterface

// ----- rtl/core/bpc_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the press event and debounced level.
// ----------------------------------------------------------------------------
interface bpc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] press_event;
	logic [1:0] debounced_level;

	modport source (output valid, output press_event, output debounced_level, input ready);
	modport sink (input valid, input press_event, input debounced_level, output ready);
endinterface

// ----- rtl/core/button_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier
// Integrating debouncer with ordinary and long press detection.
// ----------------------------------------------------------------------------
// Pipeline: the result of a sample transaction passes through the input register,
// then the result register, which holds it while the result channel stalls.
// Throughput: one sample per cycle while the result channel does not stall;
// the integrator and duration updates are a combinational read-modify-write
// between the two registers.
// Reset: arst_n clears the integrator, the duration and all valid flags, and
// loads the configuration registers with their default values.
module button_press_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	bpc_sample_if.sink                        sample,
	bpc_result_if.source                      result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bpc_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [bpc_pkg::DATA_BITS-1:0]     pwdata,
	output logic [bpc_pkg::DATA_BITS-1:0]     prdata,
	output logic                              pready
);
	import bpc_pkg::*;

	// Configuration registers.
	logic [7:0]            integrator_limit_q;
	logic [7:0]            held_threshold_q;
	logic [7:0]            released_threshold_q;
	logic [TICKS_BITS-1:0] long_press_ticks_q;
	logic [TICKS_BITS-1:0] short_press_ticks_q;
	logic                  long_press_enable_q;
	logic                  short_press_enable_q;

	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_BITS-1:2];
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integrator_limit_q   <= RST_INTEGRATOR_LIMIT;
			held_threshold_q     <= RST_HELD_THRESHOLD;
			released_threshold_q <= RST_RELEASED_THRESHOLD;
			long_press_ticks_q   <= RST_LONG_PRESS_TICKS;
			short_press_ticks_q  <= RST_SHORT_PRESS_TICKS;
			long_press_enable_q  <= 1'b0;
			short_press_enable_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_INTEGRATOR_LIMIT:   integrator_limit_q   <= pwdata[7:0];
				REG_HELD_THRESHOLD:     held_threshold_q     <= pwdata[7:0];
				REG_RELEASED_THRESHOLD: released_threshold_q <= pwdata[7:0];
				REG_LONG_PRESS_TICKS:   long_press_ticks_q   <= pwdata[TICKS_BITS-1:0];
				REG_SHORT_PRESS_TICKS:  short_press_ticks_q  <= pwdata[TICKS_BITS-1:0];
				REG_LONG_PRESS_ENABLE:  long_press_enable_q  <= pwdata[0];
				REG_SHORT_PRESS_ENABLE: short_press_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_INTEGRATOR_LIMIT:   prdata[7:0]            = integrator_limit_q;
			REG_HELD_THRESHOLD:     prdata[7:0]            = held_threshold_q;
			REG_RELEASED_THRESHOLD: prdata[7:0]            = released_threshold_q;
			REG_LONG_PRESS_TICKS:   prdata[TICKS_BITS-1:0] = long_press_ticks_q;
			REG_SHORT_PRESS_TICKS:  prdata[TICKS_BITS-1:0] = short_press_ticks_q;
			REG_LONG_PRESS_ENABLE:  prdata[0]              = long_press_enable_q;
			REG_SHORT_PRESS_ENABLE: prdata[0]              = short_press_enable_q;
			default: ;
		endcase
	end

	// Input register.
	logic valid_s1;
	logic pin_s1;
	logic advance;

	// Result register.
	logic  out_valid_q;
	code_t event_q;
	code_t level_q;

	// Debounce state.
	logic [7:0] integrator_q;
	duration_t  duration_q;

	assign advance      = valid_s1 & (~out_valid_q | result.ready);
	assign sample.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			pin_s1 <= sample.pin_high;
		end
	end

	// Next-state logic for one sample.
	logic [7:0]          integrator_nxt;
	duration_t           duration_nxt;
	code_t               event_nxt;
	code_t               level_nxt;
	logic [CMP_BITS-1:0] duration_ext;
	logic [CMP_BITS-1:0] long_ext;
	logic [CMP_BITS-1:0] short_ext;

	assign duration_ext = CMP_BITS'(duration_q);
	assign long_ext     = CMP_BITS'(long_press_ticks_q);
	assign short_ext    = CMP_BITS'(short_press_ticks_q);

	always_comb begin
		integrator_nxt = integrator_q;
		if (pin_s1 && (integrator_q < integrator_limit_q)) begin
			integrator_nxt = integrator_q + 8'd1;
		end else if (integrator_q != 8'd0) begin
			integrator_nxt = integrator_q - 8'd1;
		end

		duration_nxt = duration_q;
		event_nxt    = EVENT_NONE;
		// Held takes priority when the thresholds are crossed.
		if (integrator_nxt > held_threshold_q) begin
			level_nxt = LEVEL_HELD;
			if (duration_q != {DURATION_BITS{1'b1}}) begin
				duration_nxt = duration_q + duration_t'(1);
			end
		end else if (integrator_nxt < released_threshold_q) begin
			level_nxt = LEVEL_RELEASED;
			if ((duration_ext > long_ext) && long_press_enable_q) begin
				event_nxt = EVENT_LONG;
			end else if ((duration_ext > short_ext) && short_press_enable_q) begin
				event_nxt = EVENT_PRESS;
			end
			duration_nxt = '0;
		end else begin
			level_nxt = LEVEL_BETWEEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integrator_q <= '0;
			duration_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				integrator_q <= integrator_nxt;
				duration_q   <= duration_nxt;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= event_nxt;
			level_q <= level_nxt;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.press_event     = event_q;
	assign result.debounced_level = level_q;

endmodule
